/* hdl/rnn_forward_step_macros.svh */
// Assertion macros for the recurrent cell.
`ifndef RNN_FORWARD_STEP_MACROS_SVH
`define RNN_FORWARD_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define RFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RFS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rfs_pkg.sv */
// Shared types, codes and activation functions of the recurrent cell.
package rfs_pkg;

    typedef enum logic [1:0] {
        ACT_WR_INPUT = 2'd0,
        ACT_WR_REC   = 2'd1,
        ACT_WR_OUT   = 2'd2,
        ACT_TOKEN    = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] weight;
        logic [3:0]         token;
        logic               first;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  out_index;
        logic [12:0] out_value;
        logic        last;
    } out_word_t;

    localparam int MAX_EMIT = 16;
    localparam logic signed [13:0] ONE_Q12 = 14'sd4096;

    // tanh magnitude on a Q.12 magnitude, saturating at 4.0
    function automatic logic [12:0] tanh_mag(input logic [47:0] a);
        logic [12:0] knot [0:16];
        logic [3:0]  seg;
        logic [9:0]  frac;
        logic [12:0] lo;
        logic [12:0] hi;
        logic [23:0] prod;
        knot = '{13'd0, 13'd1003, 13'd1893, 13'd2602, 13'd3119, 13'd3475, 13'd3707,
                 13'd3856, 13'd3949, 13'd4006, 13'd4041, 13'd4062, 13'd4076, 13'd4084,
                 13'd4089, 13'd4091, 13'd4096};
        seg  = a[13:10];
        frac = a[9:0];
        lo   = knot[seg];
        hi   = knot[{1'b0, seg} + 5'd1];
        prod = 24'(hi - lo) * 24'(frac) + 24'd512;
        if (a >= 48'd16384) begin
            tanh_mag = 13'd4096;
        end else begin
            tanh_mag = lo + 13'(prod >> 10);
        end
    endfunction

endpackage

/* hdl/rfs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module rfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/rfs_mac.sv */
// Multiply-accumulate datapath with Q.12 rounding and activation.
module rfs_mac (
    input  logic               aclk,
    input  logic               clr,
    input  logic               acc_en,
    input  logic signed [15:0] a,
    input  logic signed [13:0] b,
    input  logic               bias_en,
    input  logic signed [15:0] bias,
    output logic signed [13:0] tanh_y,
    output logic [12:0]        sig_y
);
    logic signed [29:0] prod_reg;
    logic signed [29:0] prod_next;
    logic signed [47:0] acc_reg;
    logic signed [47:0] acc_next;
    logic signed [35:0] q12;
    logic [47:0]        mag;
    logic [12:0]        t_tanh;
    logic [12:0]        t_sig;

    // product then accumulate
    always_comb begin
        prod_next = a * b;
        acc_next  = acc_reg;
        if (clr) begin
            acc_next = '0;
        end else if (bias_en) begin
            acc_next = acc_reg + (48'(bias) <<< 12);
        end else if (acc_en) begin
            acc_next = acc_reg + 48'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // rounding half up and activations
    always_comb begin
        q12    = 36'((acc_reg + 48'sd2048) >>> 12);
        mag    = q12[35] ? 48'(-q12) : 48'(q12);
        t_tanh = rfs_pkg::tanh_mag(mag);
        t_sig  = rfs_pkg::tanh_mag((mag + 48'd1) >> 1);
        tanh_y = q12[35] ? -$signed({1'b0, t_tanh}) : $signed({1'b0, t_tanh});
        if (q12[35]) begin
            sig_y = 13'((14'd4097 - {1'b0, t_sig}) >> 1);
        end else begin
            sig_y = 13'((14'd4097 + {1'b0, t_sig}) >> 1);
        end
    end
endmodule

/* hdl/rnn_forward_step.sv */
// One token runs a hidden pass over HIDDEN_DIM rows and an output pass over EMIT rows,
// after zeroing the hidden vector when first is set or on the first token after reset;
// each output row also waits until m_ready has freed the output register. The time is
// set by the single shared multiply-accumulate unit, which walks the weight memories one
// entry per cycle, then lets its pipeline drain, with one write-back per row; weight
// writes can follow back to back. Weights live in three RAMs and the hidden vector in
// two ping-pong RAM banks. Results leave through a one-word output register; unwritten
// weights read as junk.
`include "rnn_forward_step_macros.svh"
module rnn_forward_step #(
    parameter int INPUT_DIM  = 16,
    parameter int HIDDEN_DIM = 16,
    parameter int OUTPUT_DIM = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rfs_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rfs_pkg::out_word_t m_data
);
    localparam int HB = (HIDDEN_DIM > 1) ? $clog2(HIDDEN_DIM) : 1;
    localparam int IB = $clog2(INPUT_DIM);
    localparam int OB = (OUTPUT_DIM > 1) ? $clog2(OUTPUT_DIM) : 1;
    localparam int EMIT = (OUTPUT_DIM < rfs_pkg::MAX_EMIT) ? OUTPUT_DIM : rfs_pkg::MAX_EMIT;
    localparam int WD = 16;
    localparam int CW = HB + 1;
    localparam int RW = (CW > 4) ? CW : 4;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HCLR  = 6'b000010,
        ST_HROW  = 6'b000100,
        ST_HFIN  = 6'b001000,
        ST_OROW  = 6'b010000,
        ST_OFIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [IB-1:0] tok_reg, tok_next;
    logic          tok_ok_reg, tok_ok_next;
    logic          bank_reg, bank_next;
    logic          fin_reg, fin_next;
    logic          clr_pend_reg, clr_pend_next;
    logic [2:0]    pipe_reg, pipe_next;
    logic          out_v_reg, out_v_next;
    rfs_pkg::out_word_t out_reg, out_next;

    // memory ports
    logic                 wi_we, wr_we, wo_we;
    logic [HB+IB-1:0]     wi_ra;
    logic [2*HB-1:0]      wr_ra;
    logic [OB+HB-1:0]     wo_ra;
    logic [WD-1:0]        wi_rd, wr_rd, wo_rd;
    logic [1:0]           h_we;
    logic [HB-1:0]        h_wa;
    logic [13:0]          h_wd;
    logic [HB-1:0]        h_ra;
    logic [13:0]          h_rd0, h_rd1, h_rd;
    logic                 rd_is_out_reg, rd_is_out_next;

    logic               mac_clr, mac_acc, mac_bias;
    logic signed [13:0] tanh_y;
    logic [12:0]        sig_y;
    logic               s_fire, m_fire, wr_ok;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    always_comb begin
        case (s_data.action)
            rfs_pkg::ACT_WR_INPUT: wr_ok = (32'(s_data.row) < HIDDEN_DIM) &&
                                           (32'(s_data.col) < INPUT_DIM);
            rfs_pkg::ACT_WR_REC:   wr_ok = (32'(s_data.row) < HIDDEN_DIM) &&
                                           (32'(s_data.col) < HIDDEN_DIM);
            rfs_pkg::ACT_WR_OUT:   wr_ok = (32'(s_data.row) < OUTPUT_DIM) &&
                                           (32'(s_data.col) < HIDDEN_DIM);
            default:               wr_ok = 1'b0;
        endcase
    end

    rfs_ram #(.WIDTH(WD), .DEPTH(HIDDEN_DIM * (1 << IB))) u_wi (
        .aclk(aclk), .we(wi_we),
        .waddr((HB+IB)'({(HB+IB)'(s_data.row) << IB} | (HB+IB)'(s_data.col))),
        .wdata(s_data.weight), .raddr(wi_ra), .rdata(wi_rd));
    rfs_ram #(.WIDTH(WD), .DEPTH(HIDDEN_DIM << HB)) u_wr (
        .aclk(aclk), .we(wr_we),
        .waddr((2*HB)'({(2*HB)'(s_data.row) << HB} | (2*HB)'(s_data.col))),
        .wdata(s_data.weight), .raddr(wr_ra), .rdata(wr_rd));
    rfs_ram #(.WIDTH(WD), .DEPTH(OUTPUT_DIM << HB)) u_wo (
        .aclk(aclk), .we(wo_we),
        .waddr((OB+HB)'({(OB+HB)'(s_data.row) << HB} | (OB+HB)'(s_data.col))),
        .wdata(s_data.weight), .raddr(wo_ra), .rdata(wo_rd));
    rfs_ram #(.WIDTH(14), .DEPTH(1 << HB)) u_h0 (
        .aclk(aclk), .we(h_we[0]), .waddr(h_wa), .wdata(h_wd),
        .raddr(h_ra), .rdata(h_rd0));
    rfs_ram #(.WIDTH(14), .DEPTH(1 << HB)) u_h1 (
        .aclk(aclk), .we(h_we[1]), .waddr(h_wa), .wdata(h_wd),
        .raddr(h_ra), .rdata(h_rd1));

    // bank_reg holds the old vector during the hidden pass and the new one after it flips
    assign h_rd = bank_reg ? h_rd1 : h_rd0;

    rfs_mac u_mac (
        .aclk(aclk), .clr(mac_clr), .acc_en(mac_acc),
        .a(rd_is_out_reg ? $signed(wo_rd) : $signed(wr_rd)), .b($signed(h_rd)),
        .bias_en(mac_bias), .bias(tok_ok_reg ? $signed(wi_rd) : 16'sd0),
        .tanh_y(tanh_y), .sig_y(sig_y));

    // sequencer: col walks reads; pipe tracks read->product->accumulate delay
    always_comb begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        tok_next    = tok_reg;
        tok_ok_next = tok_ok_reg;
        bank_next   = bank_reg;
        fin_next    = fin_reg;
        clr_pend_next = clr_pend_reg;
        pipe_next   = {pipe_reg[1:0], 1'b0};
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        wi_we = 1'b0; wr_we = 1'b0; wo_we = 1'b0;
        h_we = 2'b00; h_wa = row_reg[HB-1:0]; h_wd = tanh_y;
        h_ra  = col_reg[HB-1:0];
        wi_ra = (HB+IB)'({(HB+IB)'(row_reg[HB-1:0]) << IB} | (HB+IB)'(tok_reg));
        wr_ra = (2*HB)'({(2*HB)'(row_reg[HB-1:0]) << HB} | (2*HB)'(col_reg[HB-1:0]));
        wo_ra = (OB+HB)'({(OB+HB)'(row_reg) << HB} | (OB+HB)'(col_reg[HB-1:0]));
        mac_clr = 1'b0; mac_acc = pipe_reg[1]; mac_bias = 1'b0;
        if (m_fire) begin
            out_v_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    wi_we = wr_ok && (s_data.action == rfs_pkg::ACT_WR_INPUT);
                    wr_we = wr_ok && (s_data.action == rfs_pkg::ACT_WR_REC);
                    wo_we = wr_ok && (s_data.action == rfs_pkg::ACT_WR_OUT);
                    if (s_data.action == rfs_pkg::ACT_TOKEN) begin
                        tok_next    = IB'(s_data.token);
                        tok_ok_next = (32'(s_data.token) < INPUT_DIM);
                        row_next    = '0;
                        col_next    = '0;
                        // hidden vector RAMs are not reset, so clear once after reset or when first is set
                        state_next  = (s_data.first || clr_pend_reg) ? ST_HCLR : ST_HROW;
                        clr_pend_next = 1'b0;
                        mac_clr     = 1'b1;
                        fin_next    = 1'b0;
                    end
                end
            end
            ST_HCLR: begin
                // zero the current bank one entry per cycle
                h_we[bank_reg] = 1'b1;
                h_wa = row_reg[HB-1:0];
                h_wd = '0;
                if (32'(row_reg) == HIDDEN_DIM - 1) begin
                    row_next   = '0;
                    state_next = ST_HROW;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_HROW: begin
                // bias read issued at column 0, added in the next cycle
                mac_bias = fin_reg;
                if (32'(col_reg) < HIDDEN_DIM) begin
                    pipe_next[0] = 1'b1;
                    col_next = col_reg + 1'b1;
                end else if (pipe_reg == 3'b000) begin
                    state_next = ST_HFIN;
                end
                fin_next = (col_reg == CW'(0));
            end
            ST_HFIN: begin
                h_we[~bank_reg] = 1'b1;
                mac_clr  = 1'b1;
                col_next = '0;
                fin_next = 1'b0;
                if (32'(row_reg) == HIDDEN_DIM - 1) begin
                    row_next  = '0;
                    bank_next = ~bank_reg;
                    state_next = ST_OROW;
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_HROW;
                end
            end
            ST_OROW: begin
                if (32'(col_reg) < HIDDEN_DIM) begin
                    pipe_next[0] = 1'b1;
                    col_next = col_reg + 1'b1;
                end else if (pipe_reg == 3'b000 && !out_v_reg) begin
                    state_next = ST_OFIN;
                end
            end
            ST_OFIN: begin
                out_v_next = 1'b1;
                out_next.out_index = 4'(row_reg);
                out_next.out_value = sig_y;
                out_next.last      = (32'(row_reg) == EMIT - 1);
                mac_clr  = 1'b1;
                col_next = '0;
                if (32'(row_reg) == EMIT - 1) begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_OROW;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        rd_is_out_next = (state_next == ST_OROW) || (state_next == ST_OFIN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            bank_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            clr_pend_reg <= 1'b1;
            pipe_reg   <= '0;
            out_v_reg  <= 1'b0;
            tok_ok_reg <= 1'b0;
            rd_is_out_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            bank_reg   <= bank_next;
            fin_reg    <= fin_next;
            clr_pend_reg <= clr_pend_next;
            pipe_reg   <= pipe_next;
            out_v_reg  <= out_v_next;
            tok_ok_reg <= tok_ok_next;
            rd_is_out_reg <= rd_is_out_next;
        end
        tok_reg <= tok_next;
        out_reg <= out_next;
    end

    `RFS_ASSERT_NEXT(a_clr_first, aclk, aresetn, s_fire && clr_pend_reg && s_data.action == rfs_pkg::ACT_TOKEN, state_reg == ST_HCLR)
    `RFS_ASSERT_IMP(a_no_overwrite, aclk, aresetn, state_reg == ST_OFIN, !out_v_reg)
    `RFS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `RFS_ASSERT_IMP(a_last_idle, aclk, aresetn, state_reg == ST_OFIN && out_next.last, state_next == ST_IDLE)
endmodule

/* tb/tb_rnn_forward_step.sv */
// Testbench for the recurrent cell: weight loads, token steps and sigmoid outputs.
module tb_rnn_forward_step;

    localparam int IN_DIM  = 16;
    localparam int HID_DIM = 16;
    localparam int OUT_DIM = 16;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    rfs_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    rfs_pkg::out_word_t m_data;

    rnn_forward_step #(
        .INPUT_DIM (IN_DIM),
        .HIDDEN_DIM(HID_DIM),
        .OUTPUT_DIM(OUT_DIM)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Predictor state
    logic signed [15:0] w_in  [HID_DIM][IN_DIM];
    logic signed [15:0] w_rec [HID_DIM][HID_DIM];
    logic signed [15:0] w_out [OUT_DIM][HID_DIM];
    int                 h_vec [HID_DIM];

    rfs_pkg::out_word_t expected_words[$];
    int        fail_cnt;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off_cycles;

    localparam longint KNOT[17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856,
        3949, 4006, 4041, 4062, 4076, 4084, 4089, 4091, 4096};

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50000000;
        $display("rnn_forward_step test failed");
        $finish;
    end

    function automatic longint round_q12(longint v);
        longint t;
        t = v + 2048;
        if (t >= 0) return t / 4096;
        return -((-t + 4095) / 4096);
    endfunction

    function automatic longint tanh_abs(longint a);
        longint s, f;
        if (a >= 16384) return 4096;
        s = a >> 10;
        f = a & 1023;
        return KNOT[s] + ((KNOT[s+1] - KNOT[s]) * f + 512) / 1024;
    endfunction

    // Apply one word to the model, queue any outputs it produces
    task automatic predict_word(rfs_pkg::in_word_t w);
        int     nxt [HID_DIM];
        longint acc;
        longint x;
        longint t;
        rfs_pkg::out_word_t o;
        case (rfs_pkg::action_t'(w.action))
            rfs_pkg::ACT_WR_INPUT: w_in[w.row][w.col] = w.weight;
            rfs_pkg::ACT_WR_REC:   w_rec[w.row][w.col] = w.weight;
            rfs_pkg::ACT_WR_OUT:   w_out[w.row][w.col] = w.weight;
            rfs_pkg::ACT_TOKEN: begin
                if (w.first) foreach (h_vec[i]) h_vec[i] = 0;
                for (int r = 0; r < HID_DIM; r++) begin
                    acc = longint'(w_in[r][w.token]) * 4096;
                    for (int c = 0; c < HID_DIM; c++)
                        acc += longint'(w_rec[r][c]) * h_vec[c];
                    x = round_q12(acc);
                    nxt[r] = (x < 0) ? -int'(tanh_abs(-x)) : int'(tanh_abs(x));
                end
                h_vec = nxt;
                for (int k = 0; k < OUT_DIM; k++) begin
                    acc = 0;
                    for (int c = 0; c < HID_DIM; c++)
                        acc += longint'(w_out[k][c]) * h_vec[c];
                    x = round_q12(acc);
                    t = tanh_abs(((x < 0 ? -x : x) + 1) >> 1);
                    o.out_index = 4'(k);
                    o.out_value = 13'((x < 0) ? (4096 - t + 1) / 2 : (4096 + t + 1) / 2);
                    o.last = (k == OUT_DIM - 1);
                    expected_words.push_back(o);
                end
            end
            default: ;
        endcase
    endtask

    // Offer one word, hold it until accepted; valid stays up into the next word
    task automatic send_word(rfs_pkg::in_word_t w);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(w);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic rfs_pkg::in_word_t mk_write(rfs_pkg::action_t a, int r, int c,
                                                   logic [15:0] v);
        rfs_pkg::in_word_t w;
        w = '0;
        w.action = a;
        w.row = 4'(r);
        w.col = 4'(c);
        w.weight = v;
        w.token = 4'($urandom);
        w.first = 1'($urandom);
        return w;
    endfunction

    function automatic rfs_pkg::in_word_t mk_token(int tk, bit fst);
        rfs_pkg::in_word_t w;
        w = '0;
        w.row = 4'($urandom);
        w.col = 4'($urandom);
        w.weight = 16'($urandom);
        w.action = rfs_pkg::ACT_TOKEN;
        w.token = 4'(tk);
        w.first = fst;
        return w;
    endfunction

    // Small random weight, with occasional extremes to hit saturation
    function automatic logic [15:0] rand_weight();
        case ($urandom_range(9, 0))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(2400, 0)) - 1200);
        endcase
    endfunction

    // Every weight gets a value, so no unwritten entry is ever read
    task automatic test_load_all();
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++) begin
                send_word(mk_write(rfs_pkg::ACT_WR_INPUT, r, c, rand_weight()));
                send_word(mk_write(rfs_pkg::ACT_WR_REC, r, c, rand_weight()));
                send_word(mk_write(rfs_pkg::ACT_WR_OUT, r, c, rand_weight()));
            end
    endtask

    // Extremes: full-scale weights drive tanh to its upper bound and sigmoid to both bounds
    task automatic test_directed();
        send_word(mk_token(0, 1'b1));
        send_word(mk_token(15, 1'b0));
        for (int r = 0; r < 16; r++) begin
            send_word(mk_write(rfs_pkg::ACT_WR_INPUT, r, 3, 16'h7fff));
            send_word(mk_write(rfs_pkg::ACT_WR_OUT, r, r, (r[0]) ? 16'h8000 : 16'h7fff));
        end
        send_word(mk_token(3, 1'b1));
        send_word(mk_token(3, 1'b0));
        send_word(mk_write(rfs_pkg::ACT_WR_INPUT, 0, 5, 16'h0000));
        send_word(mk_token(5, 1'b1));
        wait_drained();
    endtask

    task automatic test_random(int n);
        rfs_pkg::in_word_t w;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(2, 0) == 0)
                w = mk_write(rfs_pkg::action_t'($urandom_range(2, 0)), $urandom_range(15, 0),
                             $urandom_range(15, 0), rand_weight());
            else
                w = mk_token($urandom_range(15, 0), $urandom_range(4, 0) == 0);
            send_word(w);
        end
        wait_drained();
    endtask

    // Receiver holds off while tokens keep coming, so the input stalls
    task automatic test_backpressure();
        hold_off_cycles = 3000;
        for (int i = 0; i < 4; i++) send_word(mk_token($urandom_range(15, 0), i == 0));
        wait_drained();
    endtask

    // Sender pauses until all results are back before each token
    task automatic test_pause();
        for (int i = 0; i < 3; i++) begin
            send_word(mk_token($urandom_range(15, 0), 1'($urandom)));
            wait_drained();
        end
    endtask

    // Receiver ready with random stalls and an optional long hold-off
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles = hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
            end
        end
    end

    // Result checker
    initial begin
        rfs_pkg::out_word_t e;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: index %0d value %0d", m_data.out_index,
                           m_data.out_value);
                    fail_cnt++;
                end else begin
                    e = expected_words.pop_front();
                    if (m_data.out_index !== e.out_index) begin
                        $error("out_index: expected %0d, got %0d", e.out_index,
                               m_data.out_index);
                        fail_cnt++;
                    end
                    if (m_data.out_value !== e.out_value) begin
                        $error("out_value: expected %0d, got %0d", e.out_value,
                               m_data.out_value);
                        fail_cnt++;
                    end
                    if (m_data.last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_data.last);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        fail_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        foreach (h_vec[i]) h_vec[i] = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_load_all();
        test_directed();
        test_random(40);
        send_idle_pct = 84;
        test_random(30);
        send_idle_pct = 0;
        recv_stall_pct = 84;
        test_random(30);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        test_random(40);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_pause();

        wait_drained();
        repeat (700) @(posedge aclk);
        if (fail_cnt == 0 && expected_words.size() == 0) begin
            $display("rnn_forward_step test passed");
        end else begin
            if (expected_words.size() != 0)
                $error("%0d expected words never arrived", expected_words.size());
            $display("rnn_forward_step test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rfs_pkg.sv
hdl/rfs_ram.sv
hdl/rfs_mac.sv
hdl/rnn_forward_step.sv
tb/tb_rnn_forward_step.sv
